// ----- hw/rtl/implicit_heat_diffusion_step_defines.svh -----
`ifndef IMPLICIT_HEAT_DIFFUSION_STEP_DEFINES_SVH
`define IMPLICIT_HEAT_DIFFUSION_STEP_DEFINES_SVH

// same-cycle implication
`define IHD_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ihd assertion failed");

// next-cycle implication
`define IHD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ihd assertion failed");

`endif

// ----- hw/rtl/ihd_pkg.sv -----
package ihd_pkg;

  localparam int NODES_DEF = 32;
  localparam int TEMP_W    = 32;
  localparam int G_W       = 24;
  localparam int IDX_W     = 6;
  localparam int SUM_W     = 44;
  localparam int ACC_W     = 46;
  localparam int REM_W     = 39;
  localparam int Q_W       = 31;

  localparam logic signed [TEMP_W-1:0] RESET_TEMP = 32'sd1638400;
  localparam logic [G_W-1:0]           G_RESET    = 24'd405640;
  localparam logic [G_W-1:0]           G_MIN      = 24'd131073;
  localparam logic signed [G_W:0]      FOUR_Q16   = 25'sd262144;

  typedef enum logic [4:0] {
    S_IDLE, S_LD0, S_LD1, S_FRD, S_FWIN, S_FMUL, S_FSUM, S_FDIV,
    S_MLO, S_MHI, S_RES, S_BND0, S_BND1, S_BLAST, S_BLASTW,
    S_BRD, S_BCAP, S_ORD, S_OCAP, S_OWAIT
  } state_e;

  function automatic logic signed [TEMP_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [TEMP_W-1:0] r;
    if (v > 46'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -46'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[TEMP_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/implicit_heat_diffusion_step.sv -----
// One Crank-Nicolson step: forward elimination with a radix-2 divider,
// then back substitution and in-order readout. One item at a time.
// Reset sets all nodes to 25.0 through per-node valid bits and loads
// the reset coefficient; no clearing pass.
`include "implicit_heat_diffusion_step_defines.svh"

module implicit_heat_diffusion_step import ihd_pkg::*; #(
  parameter int NODES = NODES_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [G_W-1:0]           cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     func_i,
  input  logic signed [TEMP_W-1:0] left_temp_i,
  input  logic signed [TEMP_W-1:0] right_temp_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [IDX_W-1:0]         node_index_o,
  output logic signed [TEMP_W-1:0] node_temp_o,
  output logic                     last_o
);

  localparam int NUM_UNK = NODES - 1;
  localparam int LAST    = NODES - 2;
  localparam int TW      = $clog2(NODES + 1);
  localparam int KW      = (NUM_UNK > 1) ? $clog2(NUM_UNK) : 1;

  state_e state_q, state_d;

  logic signed [TEMP_W-1:0] tmem [NODES+1];
  logic [Q_W-1:0]           umem [NUM_UNK];
  logic signed [TEMP_W-1:0] dmem [NUM_UNK];

  logic [NODES:0]           t_valid_q;
  logic signed [TEMP_W-1:0] base_q;
  logic [G_W-1:0]           g_q, gc_q;
  logic signed [TEMP_W-1:0] left_q, right_q;
  logic signed [TEMP_W-1:0] t_rd_q, tdata;
  logic                     t_rv_q, rd_win_q;
  logic [Q_W-1:0]           u_rd_q;
  logic signed [TEMP_W-1:0] d_rd_q;
  logic signed [TEMP_W-1:0] t0_q, t1_q, t2_q;
  logic signed [56:0]       prod_q;
  logic signed [SUM_W-1:0]  s_q, addend_q, phi_q;
  logic [61:0]              plo_q;
  logic [REM_W-1:0]         rem_q, m_q;
  logic [Q_W-1:0]           u_q, prev_u_q;
  logic signed [TEMP_W-1:0] prev_d_q, x_q;
  logic [4:0]               cnt_q;
  logic [KW-1:0]            k_q;
  logic [TW-1:0]            j_q;
  logic                     phase_q;
  logic                     out_valid_q, out_last_q;
  logic [IDX_W-1:0]         out_idx_q;
  logic signed [TEMP_W-1:0] out_temp_q;

  logic [TW-1:0]            t_raddr, t_waddr;
  logic                     t_we;
  logic signed [TEMP_W-1:0] t_wdata;
  logic signed [G_W:0]      gm4;
  logic [REM_W:0]           rem2;
  logic                     ge;
  logic signed [ACC_W-1:0]  acc;
  logic signed [TEMP_W-1:0] res;
  logic                     in_acc;

  assign in_ready_o   = (state_q == S_IDLE);
  assign in_acc       = in_valid_i && in_ready_o;
  assign out_valid_o  = out_valid_q;
  assign node_index_o = out_idx_q;
  assign node_temp_o  = out_temp_q;
  assign last_o       = out_last_q;

  assign tdata = t_rv_q ? t_rd_q : base_q;
  assign gm4   = $signed({1'b0, gc_q}) - FOUR_Q16;
  assign rem2  = {rem_q, 1'b0};
  assign ge    = rem2 >= {1'b0, m_q};
  assign acc   = ACC_W'(addend_q) + ACC_W'(phi_q) + $signed({15'b0, plo_q[61:31]});
  assign res   = sat32(acc);

  always_comb begin
    state_d = state_q;
    t_raddr = j_q;
    t_we    = 1'b0;
    t_waddr = j_q;
    t_wdata = res;
    unique case (state_q)
      S_IDLE:   if (in_acc && !func_i) state_d = S_LD0;
      S_LD0: begin
        t_raddr = '0;
        state_d = S_LD1;
      end
      S_LD1: begin
        t_raddr = TW'(1);
        state_d = S_FRD;
      end
      S_FRD: begin
        t_raddr = TW'(k_q) + TW'(2);
        state_d = S_FWIN;
      end
      S_FWIN:   state_d = S_FMUL;
      S_FMUL:   state_d = S_FSUM;
      S_FSUM:   state_d = S_FDIV;
      S_FDIV:   if (cnt_q == '0) state_d = S_MLO;
      S_MLO:    state_d = S_MHI;
      S_MHI:    state_d = S_RES;
      S_RES: begin
        if (!phase_q) begin
          state_d = (k_q == KW'(LAST)) ? S_BND0 : S_FRD;
        end else begin
          t_we    = 1'b1;
          t_waddr = TW'(k_q) + TW'(1);
          state_d = (k_q == '0) ? S_ORD : S_BRD;
        end
      end
      S_BND0: begin
        t_we    = 1'b1;
        t_waddr = '0;
        t_wdata = left_q;
        state_d = S_BND1;
      end
      S_BND1: begin
        t_we    = 1'b1;
        t_waddr = TW'(NODES);
        t_wdata = right_q;
        state_d = S_BLAST;
      end
      S_BLAST:  state_d = S_BLASTW;
      S_BLASTW: begin
        t_we    = 1'b1;
        t_waddr = TW'(NUM_UNK);
        t_wdata = d_rd_q;
        state_d = (LAST == 0) ? S_ORD : S_BRD;
      end
      S_BRD:    state_d = S_BCAP;
      S_BCAP:   state_d = S_MLO;
      S_ORD:    state_d = S_OCAP;
      S_OCAP:   state_d = S_OWAIT;
      S_OWAIT:  if (out_ready_i) state_d = out_last_q ? S_IDLE : S_ORD;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      t_valid_q   <= '0;
      base_q      <= RESET_TEMP;
      g_q         <= G_RESET;
      out_valid_q <= 1'b0;
      rd_win_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_win_q <= (state_q == S_LD0) || (state_q == S_LD1) || (state_q == S_FRD);
      if (cfg_we_i) begin
        g_q <= cfg_wdata_i;
      end
      if (in_acc && func_i) begin
        base_q    <= left_temp_i;
        t_valid_q <= '0;
      end
      if (t_we) begin
        t_valid_q[t_waddr] <= 1'b1;
      end
      if (state_q == S_OCAP) begin
        out_valid_q <= 1'b1;
      end else if (state_q == S_OWAIT && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    t_rd_q <= tmem[t_raddr];
    t_rv_q <= t_valid_q[t_raddr];
    if (t_we) begin
      tmem[t_waddr] <= t_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    u_rd_q <= umem[k_q];
    d_rd_q <= dmem[k_q];
    if (state_q == S_RES && !phase_q) begin
      umem[k_q] <= u_q;
      dmem[k_q] <= res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_win_q) begin
      t0_q <= t1_q;
      t1_q <= t2_q;
      t2_q <= tdata;
    end
    case (state_q)
      S_IDLE: begin
        left_q   <= left_temp_i;
        right_q  <= right_temp_i;
        gc_q     <= (g_q < G_MIN) ? G_MIN : g_q;
        k_q      <= '0;
        phase_q  <= 1'b0;
        prev_u_q <= '0;
        prev_d_q <= '0;
      end
      S_FMUL: prod_q <= gm4 * t1_q;
      S_FSUM: begin
        s_q <= SUM_W'(t0_q) + SUM_W'(t2_q) + SUM_W'(prod_q >>> 16) + SUM_W'(prev_d_q)
             + ((k_q == '0) ? SUM_W'(left_q) : '0)
             + ((k_q == KW'(LAST)) ? SUM_W'(right_q) : '0);
        m_q      <= {gc_q, 15'b0} - REM_W'(prev_u_q);
        addend_q <= '0;
        rem_q    <= REM_W'(1) << 31;
        u_q      <= '0;
        cnt_q    <= 5'd30;
      end
      S_FDIV: begin
        rem_q <= ge ? REM_W'(rem2 - {1'b0, m_q}) : REM_W'(rem2);
        u_q   <= {u_q[Q_W-2:0], ge};
        cnt_q <= cnt_q - 5'd1;
      end
      S_MLO:  plo_q <= 62'(s_q[30:0]) * 62'(u_q);
      S_MHI:  phi_q <= SUM_W'($signed(s_q[SUM_W-1:31]) * $signed({1'b0, u_q}));
      S_RES: begin
        if (!phase_q) begin
          prev_u_q <= u_q;
          prev_d_q <= res;
          if (k_q != KW'(LAST)) k_q <= k_q + KW'(1);
        end else begin
          x_q <= res;
          if (k_q == '0) begin
            j_q <= TW'(1);
          end else begin
            k_q <= k_q - KW'(1);
          end
        end
      end
      S_BND1: k_q <= KW'(LAST);
      S_BLASTW: begin
        x_q     <= d_rd_q;
        phase_q <= 1'b1;
        j_q     <= TW'(1);
        if (LAST != 0) k_q <= k_q - KW'(1);
      end
      S_BCAP: begin
        u_q      <= u_rd_q;
        addend_q <= SUM_W'(d_rd_q);
        s_q      <= SUM_W'(x_q);
      end
      S_OCAP: begin
        out_temp_q <= tdata;
        out_idx_q  <= IDX_W'(j_q);
        out_last_q <= (j_q == TW'(NUM_UNK));
      end
      S_OWAIT: if (out_ready_i && !out_last_q) j_q <= j_q + TW'(1);
      default: ;
    endcase
  end

  `IHD_ASSERT_IMPL(a_out_state, clk_i, rst_ni, out_valid_q, state_q == S_OWAIT)
  `IHD_ASSERT_IMPL(a_last_idx, clk_i, rst_ni, out_valid_q && out_last_q, out_idx_q == IDX_W'(NUM_UNK))
  `IHD_ASSERT_NEXT(a_step_start, clk_i, rst_ni, in_acc && !func_i, state_q == S_LD0)

endmodule

// ----- bench/testbench.sv -----
module testbench;
  import ihd_pkg::*;

  localparam int          NODES       = NODES_DEF;
  localparam int          UNK         = NODES - 1;
  localparam logic        FUNC_STEP   = 1'b0;
  localparam logic        FUNC_PRESET = 1'b1;
  localparam int          SETTLE      = 1600;
  localparam int          HOLD_CYCLES = 4000;

  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic signed [TEMP_W-1:0] temp;
    logic                     last;
  } node_result_t;

  class heat_scoreboard;
    logic [G_W-1:0]           diag;
    logic signed [TEMP_W-1:0] temps[NODES+1];
    longint                   pivots[UNK];
    longint                   rhs[UNK];
    node_result_t             pending_q[$];
    int                       errors;

    function void init();
      diag = G_RESET;
      foreach (temps[i]) temps[i] = RESET_TEMP;
      errors = 0;
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint scale_frac(longint s, longint u);
      logic signed [127:0] a;
      logic signed [127:0] b;
      logic signed [127:0] p;
      a = 128'(s);
      b = 128'(u);
      p = a * b;
      return longint'(p >>> 31);
    endfunction

    function void note_request(logic f, logic signed [TEMP_W-1:0] lt,
                               logic signed [TEMP_W-1:0] rt);
      longint       g;
      longint       gm4;
      longint       d;
      longint       pu;
      longint       pd;
      longint       m;
      longint       x;
      node_result_t r;
      if (f == FUNC_PRESET) begin
        foreach (temps[i]) temps[i] = lt;
        return;
      end
      g = (diag < G_MIN) ? longint'(G_MIN) : longint'(diag);
      gm4 = g - 262144;
      for (int k = 0; k < UNK; k++) begin
        d = longint'(temps[k]) + longint'(temps[k+2]) + ((gm4 * longint'(temps[k+1])) >>> 16);
        pu = (k > 0) ? pivots[k-1] : 0;
        pd = (k > 0) ? rhs[k-1] : 0;
        m = (g <<< 15) - pu;
        if (k == 0) d += longint'(lt);
        if (k == UNK - 1) d += longint'(rt);
        if (m == 0) m = 1;
        pivots[k] = longint'(64'h4000_0000_0000_0000 / 64'(m));
        rhs[k] = clamp32(scale_frac(d + pd, pivots[k]));
      end
      temps[0] = lt;
      temps[NODES] = rt;
      temps[UNK] = TEMP_W'(rhs[UNK-1]);
      for (int k = UNK - 2; k >= 0; k--) begin
        x = rhs[k] + scale_frac(longint'(temps[k+2]), pivots[k]);
        temps[k+1] = TEMP_W'(clamp32(x));
      end
      for (int k = 1; k <= UNK; k++) begin
        r.idx = IDX_W'(k);
        r.temp = temps[k];
        r.last = (k == UNK);
        pending_q.push_back(r);
      end
    endfunction

    function void check_result(node_result_t got);
      node_result_t want;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result idx=%0d temp=%0d", got.idx, got.temp);
        return;
      end
      want = pending_q.pop_front();
      if (want != got) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected idx=%0d temp=%0d last=%0d, got idx=%0d temp=%0d last=%0d",
                   want.idx, want.temp, want.last, got.idx, got.temp, got.last);
      end
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [G_W-1:0]           cfg_wdata_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic                     func_i;
  logic signed [TEMP_W-1:0] left_temp_i;
  logic signed [TEMP_W-1:0] right_temp_i;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [IDX_W-1:0]         node_index_o;
  logic signed [TEMP_W-1:0] node_temp_o;
  logic                     last_o;

  heat_scoreboard sb;
  bit             no_idle;
  bit             hold_req;
  bit             hold_done = 1'b0;
  int             hold_cnt = 0;

  implicit_heat_diffusion_step #(.NODES(NODES)) u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .func_i, .left_temp_i, .right_temp_i,
    .out_valid_o, .out_ready_i, .node_index_o, .node_temp_o, .last_o
  );

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  initial begin
    #40000000;
    $display("FAIL implicit_heat_diffusion_step");
    $finish;
  end

  // drain results, with random stalls and one long hold-off
  always @(posedge clk_i) begin
    node_result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.idx = node_index_o;
      got.temp = node_temp_o;
      got.last = last_o;
      sb.check_result(got);
    end
    if (hold_req && !hold_done && hold_cnt == 0) begin
      hold_cnt <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready_i <= 1'b0;
    end else if (!no_idle && $urandom_range(99) < 10) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic write_diag(logic [G_W-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    sb.diag = v;
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_request(logic f, logic signed [TEMP_W-1:0] lt,
                              logic signed [TEMP_W-1:0] rt);
    if (!no_idle && $urandom_range(99) < 10) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= f;
    left_temp_i <= lt;
    right_temp_i <= rt;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(f, lt, rt);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() > 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic logic [TEMP_W-1:0] rand_temp();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'sd1638400 + $signed($urandom_range(0, 2000000)) - 32'sd1000000;
      2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(0, 1 << 24)) - 32'sd8388608;
    endcase
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 30) send_request(FUNC_PRESET, rand_temp(), $urandom);
      else send_request(FUNC_STEP, rand_temp(), rand_temp());
    end
    wait_idle();
  endtask

  initial begin
    sb = new();
    sb.init();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    func_i = FUNC_STEP;
    left_temp_i = '0;
    right_temp_i = '0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(FUNC_STEP, 32'sd1638400, 32'sd1638400);
    send_request(FUNC_STEP, 32'sh7fffffff, 32'sh80000000);
    send_request(FUNC_PRESET, 32'sh7fffffff, 32'sd0);
    send_request(FUNC_STEP, 32'sh7fffffff, 32'sh7fffffff);
    send_request(FUNC_PRESET, 32'sh80000000, 32'shffffffff);
    send_request(FUNC_STEP, 32'sh80000000, 32'sh80000000);
    send_request(FUNC_PRESET, 32'sd0, 32'sd0);
    send_request(FUNC_STEP, 32'shffffffff, 32'sd0);
    wait_idle();
    write_diag(24'hffffff);
    send_request(FUNC_PRESET, 32'sh7fffffff, 32'sd5);
    send_request(FUNC_STEP, 32'sh7fffffff, 32'sh7fffffff);
    send_request(FUNC_STEP, 32'sh80000000, 32'sd0);
    wait_idle();
    write_diag(24'd0);
    send_request(FUNC_STEP, 32'sd6553600, 32'sh80000000);
    send_request(FUNC_STEP, 32'sd0, 32'sd0);
    wait_idle();
    write_diag(G_MIN);
    send_request(FUNC_STEP, 32'sh80000000, 32'sh7fffffff);
    send_request(FUNC_STEP, 32'sd100, 32'sd100);
    wait_idle();
    write_diag(24'd131072);
    send_request(FUNC_STEP, 32'sd1, 32'shffffffff);
    wait_idle();

    write_diag(G_W'($urandom_range(131073, 16777215)));
    random_phase(60);
    write_diag(24'hffffff);
    hold_req = 1'b1;
    random_phase(50);
    write_diag(G_MIN);
    no_idle = 1'b1;
    random_phase(50);
    no_idle = 1'b0;
    write_diag(G_W'($urandom_range(0, 131073)));
    random_phase(40);
    write_diag(G_W'($urandom));
    random_phase(50);
    write_diag(G_RESET);
    random_phase(30);

    if (sb.errors == 0) begin
      $display("PASS implicit_heat_diffusion_step");
    end else begin
      $display("FAIL implicit_heat_diffusion_step");
    end
    $finish;
  end
endmodule
